// ----- hw/rtl/amg_pkg.sv -----
// ----------------------------------------------------------------------------
// amg_pkg
// Shared types and constants for the alpha-weighted mipmap generator.
// ----------------------------------------------------------------------------
package amg_pkg;

  localparam int unsigned MipLevels = 4;
  localparam int unsigned SumW      = 18;
  localparam int unsigned AsumW     = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_SUM,
    ST_DIVS,
    ST_DIVW,
    ST_EMIT
  } amg_state_t;

  typedef enum logic [1:0] {
    K_BREAK,
    K_STORE,
    K_HOLD,
    K_QUAD
  } amg_kind_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic asum_ld;
    logic sum;
    logic div_start;
    logic div_latch;
    logic advance;
  } amg_cmd_t;

  typedef struct packed {
    amg_kind_t kind;
    logic      ch_last;
    logic      div_busy;
  } amg_status_t;

endpackage

// ----- hw/rtl/amg_div.sv -----
// ----------------------------------------------------------------------------
// amg_div
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// ----------------------------------------------------------------------------
module amg_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [amg_pkg::SumW-1:0]     dividend,
  input  logic [amg_pkg::AsumW-1:0]    divisor,
  output logic                         busy,
  output logic [7:0]                   quotient
);
  import amg_pkg::*;

  logic [AsumW-1:0] rem;
  logic [7:0]       low;
  logic [3:0]       cnt;
  logic [AsumW:0]   trial;

  assign trial = {rem, low[7]};
  assign busy  = (cnt != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 4'd0;
    end else if (start) begin
      cnt <= 4'd8;
    end else if (busy) begin
      cnt <= cnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[SumW-1:8];
      low      <= dividend[7:0];
      quotient <= 8'd0;
    end else if (busy) begin
      low <= {low[6:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem      <= AsumW'(trial - {1'b0, divisor});
        quotient <= {quotient[6:0], 1'b1};
      end else begin
        rem      <= trial[AsumW-1:0];
        quotient <= {quotient[6:0], 1'b0};
      end
    end
  end

endmodule

// ----- hw/rtl/amg_datapath.sv -----
// ----------------------------------------------------------------------------
// amg_datapath
// Level positions, row store, quad sums and result registers.
// ----------------------------------------------------------------------------
module amg_datapath #(
  parameter int unsigned TILE_EDGE = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  amg_pkg::amg_cmd_t     cmd,
  output amg_pkg::amg_status_t  status,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic [7:0]            opacity,
  output logic [2:0]            mip_level,
  output logic [2:0]            column,
  output logic [2:0]            row,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_opacity,
  output logic                  last_of_run
);
  import amg_pkg::*;

  localparam int unsigned CW    = (TILE_EDGE > 2) ? $clog2(TILE_EDGE) : 1;
  localparam int unsigned EW    = $clog2(TILE_EDGE + 1);
  localparam int unsigned Depth = 2 * TILE_EDGE;
  localparam int unsigned AW    = $clog2(Depth);

  logic [31:0]      mem [Depth];
  logic [31:0]      rd0, rd1;
  logic [31:0]      hold [MipLevels];
  logic [CW-1:0]    xs [MipLevels];
  logic [CW-1:0]    ys [MipLevels];
  logic [2:0]       lvl;
  logic [31:0]      pix;
  logic [31:0]      res;
  logic [1:0]       ch;
  logic [AsumW-1:0] asum;
  logic [SumW-1:0]  wsum;
  logic [CW-1:0]    qx, qy;
  logic [7:0]       quot;
  logic             div_busy;

  logic [1:0]       li;
  logic [EW-1:0]    e_cur, lim;
  logic [CW-1:0]    x, y;
  logic             active;
  amg_kind_t        kind;
  logic [AW-1:0]    base, addr;
  logic [31:0]      p2;
  logic [SumW-1:0]  wsum_next;
  logic [AsumW-1:0] asum_next;

  logic [2:0]       nl;
  logic [1:0]       ni;
  logic [EW-1:0]    ne, nlim;
  logic             next_quad;
  logic [CW+3:0]    colw, roww;

  assign li    = lvl[1:0];
  assign e_cur = EW'(TILE_EDGE) >> lvl;
  assign lim   = e_cur & ~EW'(1);
  assign x     = xs[li];
  assign y     = ys[li];
  assign active = (lvl < 3'(MipLevels)) && (e_cur >= EW'(2));

  always_comb begin
    if (!active || (EW'(x) >= lim) || (EW'(y) >= lim)) begin
      kind = K_BREAK;
    end else if (!y[0]) begin
      kind = K_STORE;
    end else if (!x[0]) begin
      kind = K_HOLD;
    end else begin
      kind = K_QUAD;
    end
  end

  always_comb begin
    case (li)
      2'd0:    base = AW'(0);
      2'd1:    base = AW'(TILE_EDGE);
      2'd2:    base = AW'(TILE_EDGE + TILE_EDGE / 2);
      default: base = AW'(TILE_EDGE + TILE_EDGE / 2 + TILE_EDGE / 4);
    endcase
  end
  assign addr = base + AW'(x);

  assign nl   = lvl + 3'd1;
  assign ni   = nl[1:0];
  assign ne   = EW'(TILE_EDGE) >> nl;
  assign nlim = ne & ~EW'(1);
  assign next_quad = (nl < 3'(MipLevels)) && (ne >= EW'(2)) &&
                     (EW'(xs[ni]) < nlim) && (EW'(ys[ni]) < nlim) &&
                     xs[ni][0] && ys[ni][0];

  assign status.kind     = kind;
  assign status.ch_last  = (ch == 2'd2);
  assign status.div_busy = div_busy;

  assign p2 = hold[li];
  assign asum_next = AsumW'(rd0[31:24]) + AsumW'(rd1[31:24]) +
                     AsumW'(p2[31:24]) + AsumW'(pix[31:24]);
  assign wsum_next = SumW'(rd0[{ch, 3'b0} +: 8] * rd0[31:24]) +
                     SumW'(rd1[{ch, 3'b0} +: 8] * rd1[31:24]) +
                     SumW'(p2[{ch, 3'b0} +: 8] * p2[31:24]) +
                     SumW'(pix[{ch, 3'b0} +: 8] * pix[31:24]);

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl <= 3'd0;
      for (int i = 0; i < MipLevels; i++) begin
        xs[i] <= '0;
        ys[i] <= '0;
      end
    end else if (cmd.load) begin
      lvl <= 3'd0;
    end else if (cmd.advance) begin
      lvl <= nl;
    end else if (cmd.eval && active) begin
      if (EW'(x) == e_cur - EW'(1)) begin
        xs[li] <= '0;
        ys[li] <= (EW'(y) == e_cur - EW'(1)) ? '0 : y + CW'(1);
      end else begin
        xs[li] <= x + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix <= {opacity, blue, green, red};
    end else if (cmd.advance) begin
      pix <= res;
    end
    if (cmd.eval && kind == K_STORE) begin
      mem[addr] <= pix;
    end
    if (cmd.eval && kind == K_HOLD) begin
      hold[li] <= pix;
    end
    if (cmd.eval) begin
      rd0 <= mem[addr - AW'(1)];
      rd1 <= mem[addr];
      qx  <= x;
      qy  <= y;
    end
    if (cmd.asum_ld) begin
      asum <= asum_next;
      ch   <= 2'd0;
      res[31:24] <= asum_next[AsumW-1:2];
    end
    if (cmd.sum) begin
      wsum <= wsum_next;
    end
    if (cmd.div_latch) begin
      res[{ch, 3'b0} +: 8] <= (asum == '0) ? 8'd0 : quot;
      ch <= ch + 2'd1;
    end
    if (cmd.asum_ld) begin
      mip_level <= nl;
    end
    if (cmd.div_latch && ch == 2'd2) begin
      last_of_run <= !next_quad;
    end
  end

  assign colw        = (CW + 4)'(qx) >> 1;
  assign roww        = (CW + 4)'(qy) >> 1;
  assign column      = colw[2:0];
  assign row         = roww[2:0];
  assign out_red     = res[7:0];
  assign out_green   = res[15:8];
  assign out_blue    = res[23:16];
  assign out_opacity = res[31:24];

  amg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (wsum),
    .divisor  (asum),
    .busy     (div_busy),
    .quotient (quot)
  );

endmodule

// ----- hw/rtl/amg_ctrl.sv -----
// ----------------------------------------------------------------------------
// amg_ctrl
// Sequencer for level walk, quad sums, divisions and result handoff.
// ----------------------------------------------------------------------------
module amg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  amg_pkg::amg_status_t  status,
  output amg_pkg::amg_cmd_t     cmd
);
  import amg_pkg::*;

  amg_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EVAL;
      ST_EVAL: state_next = (status.kind == K_QUAD) ? ST_READ : ST_IDLE;
      ST_READ: state_next = ST_SUM;
      ST_SUM:  state_next = ST_DIVS;
      ST_DIVS: state_next = ST_DIVW;
      ST_DIVW: begin
        if (!status.div_busy) begin
          state_next = status.ch_last ? ST_EMIT : ST_SUM;
        end
      end
      ST_EMIT: if (out_ready) state_next = ST_EVAL;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EVAL: cmd.eval      = 1'b1;
      ST_READ: cmd.asum_ld   = 1'b1;
      ST_SUM:  cmd.sum       = 1'b1;
      ST_DIVS: cmd.div_start = 1'b1;
      ST_DIVW: cmd.div_latch = !status.div_busy;
      ST_EMIT: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- hw/rtl/alpha_weighted_mipmap_generator_top.sv -----
// ----------------------------------------------------------------------------
// alpha_weighted_mipmap_generator_top
// Streams an RGBA8 tile in raster order and emits its alpha-weighted mipmaps.
// ----------------------------------------------------------------------------
// A pixel that ends no quad is looked up, then the block is idle again. A quad result is offered
// after its pixel, or the result of the level below it, is handed over: the
// level is looked up and alpha is summed, then each colour is summed and divided
// by the shared bit-serial divider (start, 8 steps, latch). One pixel
// releases up to four results, one level after another, and the next pixel is
// taken once the last of them has been handed off.
module alpha_weighted_mipmap_generator_top #(
  parameter int unsigned TILE_EDGE = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] opacity,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] mip_level,
  output logic [2:0] column,
  output logic [2:0] row,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_opacity,
  output logic       last_of_run
);
  import amg_pkg::*;

  amg_cmd_t    cmd;
  amg_status_t status;

  amg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  amg_datapath #(.TILE_EDGE(TILE_EDGE)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .opacity     (opacity),
    .mip_level   (mip_level),
    .column      (column),
    .row         (row),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_opacity (out_opacity),
    .last_of_run (last_of_run)
  );

endmodule

// ----- hw/rtl/amg_checker.sv -----
// ----------------------------------------------------------------------------
// amg_checker
// Port-level checks for the mipmap generator, bound to the top level.
// ----------------------------------------------------------------------------
module amg_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] mip_level,
  input logic [7:0] out_red,
  input logic [7:0] out_opacity,
  input logic       last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_red) &&
    $stable(out_opacity) && $stable(mip_level) && $stable(last_of_run))
    else $error("stalled result changed");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while result pending");

  a_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mip_level == 3'd1 || mip_level == 3'd2 ||
                   mip_level == 3'd3 || mip_level == 3'd4))
    else $error("bad mip level");

  a_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("result too soon after input");

endmodule

bind alpha_weighted_mipmap_generator_top amg_checker u_amg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .mip_level   (mip_level),
  .out_red     (out_red),
  .out_opacity (out_opacity),
  .last_of_run (last_of_run)
);

// ----- sim/tb_alpha_weighted_mipmap_generator_top.sv -----
// ----------------------------------------------------------------------------
// tb_alpha_weighted_mipmap_generator_top
// Streams 16x16 tile pixels into the mipmap generator and checks every coarser
// pixel against a behavioral predictor, under several idle and stall phases.
// ----------------------------------------------------------------------------
module tb_alpha_weighted_mipmap_generator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Edge = 16;
  localparam int unsigned StoreDepth = 2 * Edge;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [2:0] lvl;
    logic [2:0] col;
    logic [2:0] rw;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       last;
  } mip_px_t;

  typedef struct {
    logic [31:0] px;
    logic        typed;
    mip_px_t     res;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [7:0] red = 0, green = 0, blue = 0, opacity = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [2:0] mip_level, column, row;
  logic [7:0] out_red, out_green, out_blue, out_opacity;
  logic last_of_run;

  alpha_weighted_mipmap_generator_top #(.TILE_EDGE(Edge)) uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  int unsigned tile_pos;
  int unsigned lvl_pos[3];
  logic [31:0] row_store[StoreDepth];
  logic [31:0] left_hold[4];
  mip_px_t mip_expected[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 0;
  int quiet = 0;
  bit tx_in, tx_out;

  function automatic logic [31:0] quad_avg(logic [31:0] p0, logic [31:0] p1,
                                           logic [31:0] p2, logic [31:0] p3);
    logic [31:0] q[4];
    logic [31:0] res;
    int unsigned asum, s;
    q = '{p0, p1, p2, p3};
    asum = 0;
    for (int k = 0; k < 4; k++) asum += q[k][31:24];
    res = 0;
    res[31:24] = 8'(asum / 4);
    if (asum > 0) begin
      for (int c = 0; c < 3; c++) begin
        s = 0;
        for (int k = 0; k < 4; k++) s += q[k][8*c +: 8] * q[k][31:24];
        res[8*c +: 8] = 8'(s / asum);
      end
    end
    return res;
  endfunction

  task automatic predict_mips(logic [31:0] pin);
    logic [31:0] pix;
    int unsigned e, pos, x, y, base;
    int n;
    mip_px_t m;
    pix = pin;
    e = Edge;
    base = 0;
    n = 0;
    for (int lvl = 0; lvl < 4; lvl++) begin
      if (e < 2) break;
      pos = (lvl == 0) ? tile_pos : lvl_pos[lvl-1];
      pos = pos % (e * e);
      x = pos % e;
      y = pos / e;
      if (lvl == 0) tile_pos = (pos + 1) % (e * e);
      else lvl_pos[lvl-1] = (pos + 1) % (e * e);
      if (x >= (e & ~1) || y >= (e & ~1)) break;
      if (y % 2 == 0) begin
        if (base + x < StoreDepth) row_store[base + x] = pix;
        break;
      end
      if (x % 2 == 0) begin
        left_hold[lvl] = pix;
        break;
      end
      pix = quad_avg(row_store[base + x - 1], row_store[base + x], left_hold[lvl], pix);
      m.lvl = 3'(lvl + 1);
      m.col = 3'(x / 2);
      m.rw = 3'(y / 2);
      {m.a, m.b, m.g, m.r} = pix;
      m.last = 0;
      mip_expected.push_back(m);
      n++;
      base += e;
      e = e / 2;
    end
    if (n > 0) mip_expected[$].last = 1;
  endtask

  task automatic send_pixel(logic [31:0] p);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    in_valid <= 1;
    {opacity, blue, green, red} <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_mips(p);
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    mip_px_t e;
    tx_in = in_valid && in_ready;
    tx_out = out_valid && out_ready;
    quiet <= (tx_in || tx_out || rst) ? 0 : quiet + 1;
    if (!rst && tx_out) begin
      if (mip_expected.size() == 0) begin
        $error("unexpected transaction level %0d", mip_level);
        errors++;
      end else begin
        e = mip_expected.pop_front();
        check_field("mip_level", 8'(e.lvl), 8'(mip_level));
        check_field("column", 8'(e.col), 8'(column));
        check_field("row", 8'(e.rw), 8'(row));
        check_field("out_red", e.r, out_red);
        check_field("out_green", e.g, out_green);
        check_field("out_blue", e.b, out_blue);
        check_field("out_opacity", e.a, out_opacity);
        check_field("last_of_run", 8'(e.last), 8'(last_of_run));
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (quiet >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  stim_row_t table_rows[$];

  task automatic add_row(logic [31:0] p, logic typed, mip_px_t r);
    stim_row_t s;
    s.px = p;
    s.typed = typed;
    s.res = r;
    table_rows.push_back(s);
  endtask

  task automatic send_burst(int mode, int count);
    logic [31:0] p;
    for (int i = 0; i < count; i++) begin
      case (mode)
        0: p = {$urandom_range(1) ? 8'hff : 8'h00, 24'($urandom)};
        1: p = $urandom;
        default: p = {$urandom_range(3) == 0 ? 8'h00 : 8'($urandom), 24'($urandom)};
      endcase
      send_pixel(p);
    end
  endtask

  task automatic drain;
    in_valid <= 0;
    while (mip_expected.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  initial begin
    mip_px_t none;
    none = '0;
    for (int i = 0; i < StoreDepth; i++) row_store[i] = 0;
    for (int i = 0; i < 4; i++) left_hold[i] = 0;
    for (int i = 0; i < 3; i++) lvl_pos[i] = 0;
    tile_pos = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: first two rows, extremes; first quad all white opaque
    for (int i = 0; i < 2 * Edge; i++) begin
      case (i % 4)
        0: add_row(32'hffffffff, 0, none);
        1: add_row(32'hffffffff, 0, none);
        2: add_row(32'h00000000, 0, none);
        default: add_row(32'h80ff00ff, 0, none);
      endcase
    end
    table_rows[Edge] = '{32'hffffffff, 1'b0, none};
    table_rows[Edge+1].px = 32'hffffffff;
    table_rows[Edge+1].typed = 1;
    table_rows[Edge+1].res = '{3'd1, 3'd0, 3'd0, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1};
    // fully transparent quad gives zero
    table_rows[2].px = 0; table_rows[3].px = 0;
    table_rows[Edge+2].px = 32'h00ffffff; table_rows[Edge+3].px = 32'h00ffffff;
    table_rows[Edge+3].typed = 1;
    table_rows[Edge+3].res = '{3'd1, 3'd1, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1};
    foreach (table_rows[i]) begin
      send_pixel(table_rows[i].px);
      if (table_rows[i].typed && mip_expected[$] !== table_rows[i].res) begin
        $error("predictor row %0d disagrees with table", i);
        errors++;
      end
    end
    drain();

    // rest of the first tile up to row 7, across idle and stall phases
    idle_pct = 0;  stall_pct = 0;  send_burst(0, 22);
    idle_pct = 67; stall_pct = 0;  send_burst(1, 22);
    idle_pct = 0;  stall_pct = 67; send_burst(2, 22);
    drain();
    idle_pct = 16; stall_pct = 16;
    fork
      begin
        hold_off = 1;
        repeat (600) @(negedge clk);
        hold_off = 0;
      end
      send_burst(1, 22);
    join
    drain();

    if (errors == 0 && mip_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
